// ----- design/strict_priority_message_queues_top_macros.svh -----
// Assertion helpers used by the queue controller.
`ifndef STRICT_PRIORITY_MESSAGE_QUEUES_TOP_MACROS_SVH
`define STRICT_PRIORITY_MESSAGE_QUEUES_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SPMQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SPMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/spmq_pkg.sv -----
package spmq_pkg;

  localparam int NUM_LEVELS = 4;
  localparam int LVL_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int DATA_W     = 3 * BYTE_W;

  localparam int LEVEL0_DEPTH = 4;
  localparam int LEVEL1_DEPTH = 8;
  localparam int LEVEL2_DEPTH = 8;
  localparam int LEVEL3_DEPTH = 16;

  localparam int LEVEL_DEPTH [NUM_LEVELS] =
    '{LEVEL0_DEPTH, LEVEL1_DEPTH, LEVEL2_DEPTH, LEVEL3_DEPTH};

  localparam int MAX_01    = (LEVEL0_DEPTH > LEVEL1_DEPTH) ? LEVEL0_DEPTH : LEVEL1_DEPTH;
  localparam int MAX_23    = (LEVEL2_DEPTH > LEVEL3_DEPTH) ? LEVEL2_DEPTH : LEVEL3_DEPTH;
  localparam int MAX_DEPTH = (MAX_01 > MAX_23) ? MAX_01 : MAX_23;

  // Pointers index the deepest level; counts reach the depth itself.
  localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    ACT_SEND = 1'b0,
    ACT_GET  = 1'b1
  } action_t;

  // Decision for the item at the input, from controller to datapath.
  typedef struct packed {
    logic             send_ok;
    logic             get_ok;
    logic [LVL_W-1:0] lvl;
    ptr_t             wptr;
    ptr_t             rptr;
  } spmq_op_t;

  function automatic cnt_t level_depth(logic [LVL_W-1:0] lvl);
    return CNT_W'(LEVEL_DEPTH[lvl]);
  endfunction

  // Step a ring pointer, wrapping at the level depth.
  function automatic ptr_t ptr_advance(ptr_t ptr, cnt_t depth);
    cnt_t nxt;
    nxt = {1'b0, ptr} + CNT_W'(1);
    return (nxt >= depth) ? '0 : nxt[PTR_W-1:0];
  endfunction

endpackage

// ----- design/spmq_ifs.sv -----
interface spmq_in_if;
  import spmq_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [LVL_W-1:0]  priority_req;
  logic [BYTE_W-1:0] msg_id;
  logic [BYTE_W-1:0] param_low;
  logic [BYTE_W-1:0] param_high;

  modport source (output valid, action, priority_req, msg_id, param_low, param_high,
                  input ready);
  modport sink   (input valid, action, priority_req, msg_id, param_low, param_high,
                  output ready);
endinterface

interface spmq_out_if;
  import spmq_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [BYTE_W-1:0] out_id;
  logic [LVL_W-1:0]  out_priority;
  logic [BYTE_W-1:0] out_low;
  logic [BYTE_W-1:0] out_high;

  modport source (output valid, ok, out_id, out_priority, out_low, out_high,
                  input ready);
  modport sink   (input valid, ok, out_id, out_priority, out_low, out_high,
                  output ready);
endinterface

// ----- design/spmq_ram.sv -----
module spmq_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 24,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/spmq_ctrl.sv -----
`include "strict_priority_message_queues_top_macros.svh"

module spmq_ctrl import spmq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  action_t          action,
  input  logic [LVL_W-1:0] priority_req,
  output spmq_op_t         op
);

  ptr_t wp_r  [NUM_LEVELS];
  ptr_t rp_r  [NUM_LEVELS];
  cnt_t cnt_r [NUM_LEVELS];

  logic             found;
  logic [LVL_W-1:0] get_lvl;
  logic             cnt_in_range;

  // Pick the highest-priority nonempty level
  always_comb begin
    found   = 1'b0;
    get_lvl = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (!found && (cnt_r[l] != '0)) begin
        found   = 1'b1;
        get_lvl = LVL_W'(l);
      end
    end
  end

  // Decide the operation for the item at the input
  always_comb begin
    op = '0;
    if (action == ACT_SEND) begin
      op.lvl     = priority_req;
      op.send_ok = cnt_r[priority_req] < level_depth(priority_req);
    end else begin
      op.lvl    = get_lvl;
      op.get_ok = found;
    end
    op.wptr = wp_r[op.lvl];
    op.rptr = rp_r[op.lvl];
  end

  // Advance pointers and counts on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        wp_r[l]  <= '0;
        rp_r[l]  <= '0;
        cnt_r[l] <= '0;
      end
    end else if (take) begin
      if (op.send_ok) begin
        wp_r[op.lvl]  <= ptr_advance(op.wptr, level_depth(op.lvl));
        cnt_r[op.lvl] <= cnt_r[op.lvl] + CNT_W'(1);
      end
      if (op.get_ok) begin
        rp_r[op.lvl]  <= ptr_advance(op.rptr, level_depth(op.lvl));
        cnt_r[op.lvl] <= cnt_r[op.lvl] - CNT_W'(1);
      end
    end
  end

  // Occupancy never passes the level depth
  always_comb begin
    cnt_in_range = 1'b1;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (cnt_r[l] > level_depth(LVL_W'(l))) begin
        cnt_in_range = 1'b0;
      end
    end
  end

  `SPMQ_ASSERT_SAME(a_cnt_range, clk, rst_n, 1'b1, cnt_in_range, "level count above depth")
  `SPMQ_ASSERT_SAME(a_get_empty, clk, rst_n,
    (action == ACT_GET) && (cnt_r[0] == '0) && (cnt_r[1] == '0) &&
    (cnt_r[2] == '0) && (cnt_r[3] == '0), !op.get_ok, "get succeeded with all levels empty")
  `SPMQ_ASSERT_NEXT(a_send_cnt, clk, rst_n, take && op.send_ok,
    cnt_r[$past(op.lvl)] == $past(cnt_r[op.lvl]) + CNT_W'(1), "send did not bump count")
  `SPMQ_ASSERT_NEXT(a_get_cnt, clk, rst_n, take && op.get_ok,
    cnt_r[$past(op.lvl)] == $past(cnt_r[op.lvl]) - CNT_W'(1), "get did not drop count")

endmodule

// ----- design/strict_priority_message_queues_top.sv -----
// An input transfer's result is in the output register in the cycle after it.
// One item per cycle unless the output stalls; every send or get touches a single
// entry of one level's ring buffer, for gets picked by a four-way priority encode.
// Reset (rst_n low, synchronous) empties every level and drops any held result;
// buffer contents are not cleared and are never read before being written.
module strict_priority_message_queues_top import spmq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  spmq_in_if.sink    in_ch,
  spmq_out_if.source out_ch
);

  spmq_op_t          op;
  logic              take;
  logic              out_valid_r;
  logic              ok_r;
  logic              get_ok_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rd_data [NUM_LEVELS];
  logic [DATA_W-1:0] sel_data;

  // Accept while the result register is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign wr_data     = {in_ch.param_high, in_ch.param_low, in_ch.msg_id};

  spmq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .action       (action_t'(in_ch.action)),
    .priority_req (in_ch.priority_req),
    .op           (op)
  );

  // One ring buffer per level
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    localparam int AW_G = (LEVEL_DEPTH[g] > 1) ? $clog2(LEVEL_DEPTH[g]) : 1;

    spmq_ram #(
      .DEPTH (LEVEL_DEPTH[g]),
      .WIDTH (DATA_W)
    ) u_ram (
      .clk     (clk),
      .wr_en   (take && op.send_ok && (op.lvl == LVL_W'(g))),
      .wr_addr (op.wptr[AW_G-1:0]),
      .wr_data (wr_data),
      .rd_en   (take && op.get_ok && (op.lvl == LVL_W'(g))),
      .rd_addr (op.rptr[AW_G-1:0]),
      .rd_data (rd_data[g])
    );
  end

  // Output valid: set on transfer in, clear on transfer out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold result status alongside the buffer read data
  always_ff @(posedge clk) begin
    if (take) begin
      ok_r     <= op.send_ok || op.get_ok;
      get_ok_r <= op.get_ok;
      lvl_r    <= op.get_ok ? op.lvl : '0;
    end
  end

  assign sel_data = rd_data[lvl_r];

  // Zero the payload unless a message was returned
  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = ok_r;
  assign out_ch.out_priority = lvl_r;
  assign out_ch.out_id       = get_ok_r ? sel_data[BYTE_W-1:0]          : '0;
  assign out_ch.out_low      = get_ok_r ? sel_data[2*BYTE_W-1:BYTE_W]   : '0;
  assign out_ch.out_high     = get_ok_r ? sel_data[3*BYTE_W-1:2*BYTE_W] : '0;

endmodule

// ----- tb/strict_priority_message_queues_top_test.sv -----
module strict_priority_message_queues_top_test;
  import spmq_pkg::*;

  // One pending item for the driver; a hold entry makes the sender wait for
  // every outstanding result before it goes on.
  typedef struct {
    bit                hold;
    action_t           act;
    logic [LVL_W-1:0]  lvl;
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
  } msg_request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
  } stored_msg_t;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] id;
    logic [LVL_W-1:0]  lvl;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
  } msg_reply_t;

  localparam int RX_STEADY = 0;
  localparam int RX_LIGHT  = 1;
  localparam int RX_HEAVY  = 2;

  localparam int RANDOM_ITEMS = 730;

  logic clk = 1'b0;
  logic rst_n;

  spmq_in_if  in_ch();
  spmq_out_if out_ch();

  strict_priority_message_queues_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  msg_request_t pending_q[$];
  msg_reply_t   reply_q[$];
  stored_msg_t  level_fifo[NUM_LEVELS][$];
  int           error_count = 0;
  bit           in_taken = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mirror the four rings: send appends if the level has room, get pops the
  // oldest message of the highest nonempty level.
  function automatic msg_reply_t queue_reply(action_t act, logic [LVL_W-1:0] lvl,
                                             stored_msg_t msg);
    msg_reply_t  r;
    stored_msg_t m;
    r = '0;
    if (act == ACT_SEND) begin
      if (level_fifo[lvl].size() < LEVEL_DEPTH[lvl]) begin
        level_fifo[lvl].push_back(msg);
        r.ok = 1'b1;
      end
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (!r.ok && level_fifo[l].size() != 0) begin
          m     = level_fifo[l].pop_front();
          r.ok  = 1'b1;
          r.id  = m.id;
          r.lvl = LVL_W'(l);
          r.lo  = m.lo;
          r.hi  = m.hi;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  task automatic add_send(logic [LVL_W-1:0] lvl, logic [BYTE_W-1:0] id,
                          logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi);
    msg_request_t q;
    q.hold = 1'b0;
    q.act  = ACT_SEND;
    q.lvl  = lvl;
    q.id   = id;
    q.lo   = lo;
    q.hi   = hi;
    pending_q.push_back(q);
  endtask

  task automatic add_get(logic [LVL_W-1:0] lvl, logic [BYTE_W-1:0] id,
                         logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi);
    msg_request_t q;
    q.hold = 1'b0;
    q.act  = ACT_GET;
    q.lvl  = lvl;
    q.id   = id;
    q.lo   = lo;
    q.hi   = hi;
    pending_q.push_back(q);
  endtask

  task automatic add_hold();
    msg_request_t q;
    q.hold = 1'b1;
    q.act  = ACT_SEND;
    q.lvl  = '0;
    q.id   = '0;
    q.lo   = '0;
    q.hi   = '0;
    pending_q.push_back(q);
  endtask

  // Check result transfers against the oldest expectation, then predict the
  // input transfer of this edge.
  always @(posedge clk) begin
    msg_reply_t  exp_r;
    stored_msg_t msg;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ok=%0b id=%0h lvl=%0d",
                   $time, out_ch.ok, out_ch.out_id, out_ch.out_priority);
          error_count++;
        end else begin
          exp_r = reply_q.pop_front();
          check_field("ok", exp_r.ok, out_ch.ok);
          check_field("out_id", exp_r.id, out_ch.out_id);
          check_field("out_priority", exp_r.lvl, out_ch.out_priority);
          check_field("out_low", exp_r.lo, out_ch.out_low);
          check_field("out_high", exp_r.hi, out_ch.out_high);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        msg.id = in_ch.msg_id;
        msg.lo = in_ch.param_low;
        msg.hi = in_ch.param_high;
        reply_q.push_back(queue_reply(action_t'(in_ch.action), in_ch.priority_req, msg));
        void'(pending_q.pop_front());
        in_taken = 1'b1;
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_q[0].hold) begin
        // wait here until every outstanding result has come back
        in_ch.valid <= 1'b0;
        if (reply_q.size() == 0)
          void'(pending_q.pop_front());
      end else begin
        in_ch.valid        <= 1'b1;
        in_ch.action       <= pending_q[0].act;
        in_ch.priority_req <= pending_q[0].lvl;
        in_ch.msg_id       <= pending_q[0].id;
        in_ch.param_low    <= pending_q[0].lo;
        in_ch.param_high   <= pending_q[0].hi;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
  end

  // Receiver: switch between steady, light and heavy stall stretches.
  int rx_mode = RX_STEADY;
  int rx_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_STEADY, RX_HEAVY);
      rx_left = $urandom_range(10, 60);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_STEADY: out_ch.ready <= 1'b1;
      RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 3) != 0);
      default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    #2400000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int sent;
    int phase_len;
    int send_pct;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_SEND;
    in_ch.priority_req = '0;
    in_ch.msg_id       = '0;
    in_ch.param_low    = '0;
    in_ch.param_high   = '0;
    out_ch.ready       = 1'b0;

    // Directed: get on empty, one message per level, level 0 filled past
    // full, then drain everything and get once more on empty.
    add_get(2'd3, 8'hFF, 8'hFF, 8'hFF);
    add_send(2'd3, 8'hFF, 8'h00, 8'hFF);
    add_send(2'd2, 8'h00, 8'hFF, 8'h00);
    add_send(2'd1, 8'hAA, 8'h55, 8'hA5);
    add_send(2'd0, 8'h00, 8'h00, 8'h00);
    add_send(2'd0, 8'hFF, 8'hFF, 8'hFF);
    add_send(2'd0, 8'h01, 8'h80, 8'h7F);
    add_send(2'd0, 8'h80, 8'h01, 8'hFE);
    add_send(2'd0, 8'h5A, 8'h5A, 8'h5A);
    for (int i = 0; i < 8; i++)
      add_get(LVL_W'(i), 8'(i * 37), 8'hFF, 8'h00);
    add_hold();

    // Random: phases that lean to filling, draining or a mix.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       send_pct = 85;
        1:       send_pct = 50;
        default: send_pct = 20;
      endcase
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(1, 100) <= send_pct)
          add_send(LVL_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                   BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        else
          add_get(LVL_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                  BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      end
      sent += phase_len;
      if ($urandom_range(0, 3) == 0)
        add_hold();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_q.size() != 0)
      @(posedge clk);
    while (reply_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
